// ----- sv/pra_pkg.sv -----
// Shared types and constants for the priority request arbiter.
`default_nettype none

package pra_pkg;

  // Fixed field widths
  localparam int unsigned IdxW     = 3;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned RuleW    = 9;
  localparam int unsigned NumRules = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RuleEnBit = 8;

  // Default number of behaviours (2 to 8)
  localparam int unsigned NumBehaviorsDef = 8;

  // Command codes
  typedef enum logic [1:0] {
    CmdRequest = 2'd0,
    CmdTick    = 2'd1,
    CmdClear   = 2'd2
  } cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StReqWr,
    StScan,
    StDrain,
    StDone
  } state_e;

  // Priority memory access: one write port, one read port
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [PrioW-1:0] wdata;
    logic [IdxW-1:0]  raddr;
  } mem_req_t;

  typedef logic [NumRules-1:0][RuleW-1:0] rule_arr_t;

endpackage

`default_nettype wire

// ----- sv/priority_request_arbiter_top.sv -----
// Top level of the priority request arbiter: rule registers, sequencer and priority store.
//
// A request beat keeps the block busy while it does a read-modify-write of
// the priority store; a clear beat, an unused command and a request that the
// current behaviour's rule rejects leave the block idle. A tick keeps the block
// busy through its scan, drain and done states, because the single read port of the
// priority store is swept one entry per cycle. Its result strobe is high in the
// cycle after the done state, when the block is idle again. The result is
// shown for exactly one cycle on result_valid_o and the receiver cannot hold it off.
// Rule registers are written at any edge with cfg_we_i high.
`default_nettype none

module priority_request_arbiter_top
  import pra_pkg::*;
#(
  parameter int unsigned NumBehaviors = NumBehaviorsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic        [1:0]       command_i,
  input  wire logic        [IdxW-1:0]  behavior_index_i,
  input  wire logic signed [PrioW-1:0] priority_req_i,
  input  wire logic                    cfg_we_i,
  input  wire logic        [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic        [RuleW-1:0] cfg_wdata_i,
  output logic                         result_valid_o,
  output logic             [IdxW-1:0]  current_behavior_o,
  output logic                         current_valid_o,
  output logic                         entered_o
);

  rule_arr_t        rule_q;
  mem_req_t         mem_req;
  logic [PrioW-1:0] mem_rdata;

  // Transition rule registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= '0;
    end else if (cfg_we_i) begin
      rule_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  pra_ctrl #(
    .NumBehaviors(NumBehaviors)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .behavior_index_i  (behavior_index_i),
    .priority_req_i    (priority_req_i),
    .rule_i            (rule_q),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata),
    .result_valid_o    (result_valid_o),
    .current_behavior_o(current_behavior_o),
    .current_valid_o   (current_valid_o),
    .entered_o         (entered_o)
  );

  pra_prio_mem #(
    .Depth(NumBehaviors)
  ) u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

endmodule

`default_nettype wire

// ----- sv/pra_prio_mem.sv -----
// Pending priority store: synchronous RAM, one write and one read port.
`default_nettype none

module pra_prio_mem
  import pra_pkg::*;
#(
  parameter int unsigned Depth = NumBehaviorsDef
) (
  input  wire logic             clk_i,
  input  wire mem_req_t         req_i,
  output logic      [PrioW-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(Depth);

  logic [PrioW-1:0] mem_q [Depth];
  logic [PrioW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr[AW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/pra_ctrl.sv -----
// Sequencer: request read-modify-write, tick scan over the store, result register.
`default_nettype none

module pra_ctrl
  import pra_pkg::*;
#(
  parameter int unsigned NumBehaviors = NumBehaviorsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic        [1:0]       command_i,
  input  wire logic        [IdxW-1:0]  behavior_index_i,
  input  wire logic signed [PrioW-1:0] priority_req_i,
  input  wire rule_arr_t               rule_i,
  output mem_req_t                     mem_req_o,
  input  wire logic        [PrioW-1:0] mem_rdata_i,
  output logic                         result_valid_o,
  output logic             [IdxW-1:0]  current_behavior_o,
  output logic                         current_valid_o,
  output logic                         entered_o
);

  localparam int unsigned AW = $clog2(NumBehaviors);

  state_e state_q, state_d;

  logic [AW-1:0]            scan_q;
  logic [AW-1:0]            idx_q;
  logic signed [PrioW-1:0]  prio_q;
  logic                     rd_vld_q;
  logic [AW-1:0]            rd_idx_q;
  logic signed [PrioW-1:0]  best_q;
  logic [AW-1:0]            win_q;
  logic                     found_q;
  logic [NumBehaviors-1:0]  pend_vld_q;
  logic [IdxW-1:0]          act_idx_q;
  logic                     act_vld_q;
  logic                     res_vld_q;
  logic [IdxW-1:0]          res_idx_q;
  logic                     res_cur_q;
  logic                     res_ent_q;

  logic accept;
  logic in_range;
  logic allowed;
  logic req_ok;
  logic scan_last;
  logic take_cand;
  logic entered_d;

  assign accept    = start && (state_q == StIdle);
  assign in_range  = {1'b0, behavior_index_i} < (IdxW + 1)'(NumBehaviors);
  // No active behaviour or no rule for it: every target allowed
  assign allowed   = !act_vld_q || !rule_i[act_idx_q][RuleEnBit] ||
                     rule_i[act_idx_q][behavior_index_i];
  assign req_ok    = in_range && allowed;
  assign scan_last = (scan_q == AW'(NumBehaviors - 1));

  // Scan compare: strict greater in ascending order keeps the lowest index on a tie
  assign take_cand = rd_vld_q && pend_vld_q[rd_idx_q] &&
                     (!found_q || ($signed(mem_rdata_i) > best_q));
  assign entered_d = found_q && (!act_vld_q || (IdxW'(win_q) != act_idx_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (command_i)
            CmdRequest: if (req_ok) state_d = StReqWr;
            CmdTick:    state_d = StScan;
            default:    state_d = StIdle;
          endcase
        end
      end
      StReqWr: state_d = StIdle;
      StScan:  if (scan_last) state_d = StDrain;
      StDrain: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory port and busy
  always_comb begin
    mem_req_o = '0;
    busy      = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        mem_req_o.raddr = behavior_index_i;
      end
      StReqWr: begin
        // Keep the higher priority on a repeated request
        mem_req_o.we    = !pend_vld_q[idx_q] || (prio_q > $signed(mem_rdata_i));
        mem_req_o.waddr = IdxW'(idx_q);
        mem_req_o.wdata = prio_q;
      end
      StScan: begin
        mem_req_o.raddr = IdxW'(scan_q);
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      pend_vld_q <= '0;
      act_idx_q  <= '0;
      act_vld_q  <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= (state_q == StScan);
      res_vld_q <= (state_q == StDone);

      if (accept && command_i == CmdTick) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (state_q == StScan) scan_q <= scan_q + AW'(1);
        if (take_cand) found_q <= 1'b1;
      end

      if (accept && command_i == CmdClear) begin
        pend_vld_q <= '0;
      end else if (state_q == StReqWr) begin
        pend_vld_q[idx_q] <= 1'b1;
      end else if (state_q == StDone) begin
        pend_vld_q <= '0;
      end

      if (state_q == StDone && found_q) begin
        act_idx_q <= IdxW'(win_q);
        act_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= behavior_index_i[AW-1:0];
      prio_q <= priority_req_i;
    end
    rd_idx_q <= scan_q;
    if (take_cand) begin
      best_q <= $signed(mem_rdata_i);
      win_q  <= rd_idx_q;
    end
    if (state_q == StDone) begin
      res_idx_q <= found_q ? IdxW'(win_q) : act_idx_q;
      res_cur_q <= found_q || act_vld_q;
      res_ent_q <= entered_d;
    end
  end

  assign result_valid_o     = res_vld_q;
  assign current_behavior_o = res_idx_q;
  assign current_valid_o    = res_cur_q;
  assign entered_o          = res_ent_q;

endmodule

`default_nettype wire

// ----- sv/pra_checker.sv -----
// Port-level checker for the priority request arbiter, bound to the top level.
`default_nettype none

module pra_checker
  import pra_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start,
  input wire logic            busy,
  input wire logic [1:0]      command_i,
  input wire logic            result_valid_o,
  input wire logic            current_valid_o,
  input wire logic            entered_o
);

  // A tick result is a single-cycle strobe
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one beat");

  // A switch always leaves a valid behaviour
  a_entered_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && entered_o) |-> current_valid_o)
    else $error("entered reported without a valid behaviour");

  // Results are only shown once the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted tick starts the scan
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdTick) |=> busy)
    else $error("tick accepted but block not busy");

  // A clear beat gives no result and leaves the block idle
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CmdClear) |=> (!busy && !result_valid_o))
    else $error("clear beat caused activity");

endmodule

bind priority_request_arbiter_top pra_checker u_pra_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .command_i      (command_i),
  .result_valid_o (result_valid_o),
  .current_valid_o(current_valid_o),
  .entered_o      (entered_o)
);

`default_nettype wire
